// ===== design/pal_pkg.sv =====
package pal_pkg;

    localparam int CAPACITY    = 128;
    localparam int VALUE_WIDTH = 32;

    localparam int MODE_W      = 3;
    localparam int POSITION_W  = 7;
    localparam int VALUE_PORT_W = 32;
    localparam int COUNT_PORT_W = 8;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int POS_W   = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

    localparam int GROUP_SIZE = 16;
    localparam int NGROUPS    = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [POS_W-1:0]       pos_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_POS  = 3'd0,
        MODE_INS_HEAD = 3'd1,
        MODE_INS_TAIL = 3'd2,
        MODE_REM_POS  = 3'd3,
        MODE_REM_HEAD = 3'd4,
        MODE_REM_TAIL = 3'd5
    } mode_t;

    typedef struct packed {
        logic   ins;
        logic   rem;
        pos_t   pos;
        value_t value;
    } cmd_t;

endpackage

// ===== design/pal_ctrl.sv =====
module pal_ctrl (
    input  logic                              accept,
    input  logic [pal_pkg::MODE_W-1:0]        mode,
    input  logic [pal_pkg::POSITION_W-1:0]    position,
    input  logic [pal_pkg::VALUE_PORT_W-1:0]  value,
    input  pal_pkg::cnt_t                     count,
    output pal_pkg::cmd_t                     cmd,
    output logic                              ok,
    output pal_pkg::cnt_t                     count_next
);
    import pal_pkg::*;

    pos_t pos_in;
    pos_t cnt_w;
    pos_t sel;
    logic is_ins;
    logic is_rem;

    assign pos_in = POS_W'(position);
    assign cnt_w  = POS_W'(count);

    always_comb begin
        sel    = '0;
        is_ins = 1'b0;
        is_rem = 1'b0;
        ok     = 1'b0;
        unique case (mode)
            MODE_INS_POS: begin
                is_ins = 1'b1;
                sel    = pos_in;
                ok     = (cnt_w < POS_W'(CAPACITY)) && (pos_in <= cnt_w);
            end
            MODE_INS_HEAD: begin
                is_ins = 1'b1;
                ok     = cnt_w < POS_W'(CAPACITY);
            end
            MODE_INS_TAIL: begin
                is_ins = 1'b1;
                sel    = cnt_w;
                ok     = cnt_w < POS_W'(CAPACITY);
            end
            MODE_REM_POS: begin
                is_rem = 1'b1;
                sel    = pos_in;
                ok     = pos_in < cnt_w;
            end
            MODE_REM_HEAD: begin
                is_rem = 1'b1;
                ok     = count != '0;
            end
            MODE_REM_TAIL: begin
                is_rem = 1'b1;
                sel    = cnt_w - POS_W'(1);
                ok     = count != '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        cmd.ins   = accept && ok && is_ins;
        cmd.rem   = accept && ok && is_rem;
        cmd.pos   = sel;
        cmd.value = value_t'(value);
        if (ok && is_ins) begin
            count_next = count + CNT_W'(1);
        end else if (ok && is_rem) begin
            count_next = count - CNT_W'(1);
        end else begin
            count_next = count;
        end
    end

endmodule

// ===== design/pal_cell.sv =====
module pal_cell (
    input  logic            aclk,
    input  pal_pkg::idx_t   idx,
    input  pal_pkg::cmd_t   cmd,
    input  pal_pkg::value_t left_data,
    input  pal_pkg::value_t right_data,
    output pal_pkg::value_t data,
    output pal_pkg::value_t tap
);
    import pal_pkg::*;

    value_t data_reg;
    value_t data_next;
    pos_t   my_pos;

    assign my_pos = POS_W'(idx);

    always_comb begin
        data_next = data_reg;
        if (cmd.ins) begin
            if (my_pos > cmd.pos) begin
                data_next = left_data;
            end else if (my_pos == cmd.pos) begin
                data_next = cmd.value;
            end
        end else if (cmd.rem) begin
            if (my_pos >= cmd.pos) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = (my_pos == cmd.pos) ? data_reg : '0;

endmodule

// ===== design/positional_array_list.sv =====
// Ordered list of up to CAPACITY entries kept in a row of cells; an insert shifts later
// entries up one cell, a removal shifts them down and returns the entry taken out. One item
// is accepted per cycle while results are taken; its result passes the stage-1 registers and
// then the output registers on its way to the m_ ports, and the removed
// entry is picked out by a registered OR tree over the cells (groups of 16, then across
// groups). Refused items (full, empty, position out of range, unused mode) set m_error and
// leave the list unchanged. Entries hold no reset value; only written entries are ever read.
module positional_array_list (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pal_pkg::MODE_W-1:0]         s_mode,
    input  logic [pal_pkg::POSITION_W-1:0]     s_position,
    input  logic [pal_pkg::VALUE_PORT_W-1:0]   s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pal_pkg::VALUE_PORT_W-1:0]   m_removed_value,
    output logic                               m_error,
    output logic [pal_pkg::COUNT_PORT_W-1:0]   m_count
);
    import pal_pkg::*;

    logic   accept;
    logic   advance;
    cmd_t   cmd;
    logic   ok;
    cnt_t   count_next;

    value_t cell_data [CAPACITY];
    value_t cell_tap  [CAPACITY];

    cnt_t   count_reg;
    value_t grp_reg  [NGROUPS];
    value_t grp_next [NGROUPS];
    logic   s1_valid_reg, s1_valid_next;
    logic   s1_rem_reg;
    logic   s1_err_reg;
    cnt_t   s1_cnt_reg;
    value_t grp_or;

    logic   m_valid_reg, m_valid_next;
    logic [VALUE_PORT_W-1:0] m_removed_reg;
    logic   m_error_reg;
    cnt_t   m_count_reg;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    pal_ctrl u_ctrl (
        .accept     (accept),
        .mode       (s_mode),
        .position   (s_position),
        .value      (s_value),
        .count      (count_reg),
        .cmd        (cmd),
        .ok         (ok),
        .count_next (count_next)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        value_t left_d;
        value_t right_d;
        if (i == 0) begin : g_first
            assign left_d = cell_data[i];
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        pal_cell u_cell (
            .aclk       (aclk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // first tree level: one OR per group of cells
    always_comb begin
        for (int g = 0; g < NGROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < CAPACITY) begin
                    grp_next[g] = grp_next[g] | cell_tap[g * GROUP_SIZE + k];
                end
            end
        end
    end

    always_comb begin
        grp_or = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            grp_or = grp_or | grp_reg[g];
        end
    end

    assign s1_valid_next = accept || (s1_valid_reg && !advance);
    assign m_valid_next  = advance || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            grp_reg    <= grp_next;
            s1_rem_reg <= cmd.rem;
            s1_err_reg <= !ok;
            s1_cnt_reg <= count_next;
        end
        if (advance) begin
            m_removed_reg <= s1_rem_reg ? VALUE_PORT_W'(grp_or) : '0;
            m_error_reg   <= s1_err_reg;
            m_count_reg   <= s1_cnt_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_removed_reg;
    assign m_error         = m_error_reg;
    assign m_count         = COUNT_PORT_W'(m_count_reg);

endmodule

// ===== design/pal_checker.sv =====
module pal_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [pal_pkg::VALUE_PORT_W-1:0]   m_removed_value,
    input logic                               m_error,
    input logic [pal_pkg::COUNT_PORT_W-1:0]   m_count
);
    import pal_pkg::*;

    // result item held until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_removed_value) && $stable(m_count))
        else $error("result item dropped or changed while stalled");

    // refused item returns no data
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> m_removed_value == '0)
        else $error("refused item returned data");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= COUNT_PORT_W'(CAPACITY))
        else $error("count above capacity");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

// ===== tb/sv/positional_array_list_check.sv =====
module positional_array_list_check
    import pal_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [MODE_W-1:0]       s_mode,
    input  logic [POSITION_W-1:0]   s_position,
    input  logic [VALUE_PORT_W-1:0] s_value,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic [VALUE_PORT_W-1:0] m_removed_value,
    input  logic                    m_error,
    input  logic [COUNT_PORT_W-1:0] m_count,
    output int                      fail_count,
    output int                      pending_results,
    output int                      stored_count
);

    typedef struct packed {
        logic [VALUE_PORT_W-1:0] removed;
        logic                    err;
        logic [COUNT_PORT_W-1:0] count;
    } list_result_t;

    value_t       shadow_entries [CAPACITY];
    int unsigned  list_len = 0;
    list_result_t awaited_results [$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
        stored_count    = 0;
    end

    function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] op,
                                                   input int unsigned pos,
                                                   input value_t val);
        list_result_t res;
        int unsigned  at;
        logic         is_ins;
        logic         is_rem;
        res    = '0;
        at     = pos;
        is_ins = 1'b0;
        is_rem = 1'b0;
        case (op)
            MODE_INS_POS:  is_ins = 1'b1;
            MODE_INS_HEAD: begin
                is_ins = 1'b1;
                at     = 0;
            end
            MODE_INS_TAIL: begin
                is_ins = 1'b1;
                at     = list_len;
            end
            MODE_REM_POS:  is_rem = 1'b1;
            MODE_REM_HEAD: begin
                is_rem = 1'b1;
                at     = 0;
            end
            // wraps to a huge index on an empty list, so it is refused below
            MODE_REM_TAIL: begin
                is_rem = 1'b1;
                at     = list_len - 1;
            end
            default: ;
        endcase
        if (is_ins && list_len < CAPACITY && at <= list_len) begin
            for (int unsigned i = list_len; i > at; i--)
                shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[at] = val;
            list_len++;
        end else if (is_rem && at < list_len) begin
            res.removed = VALUE_PORT_W'(shadow_entries[at]);
            list_len--;
            for (int unsigned i = at; i < list_len; i++)
                shadow_entries[i] = shadow_entries[i+1];
        end else begin
            res.err = 1'b1;
        end
        res.count = COUNT_PORT_W'(list_len);
        return res;
    endfunction

    always @(posedge aclk) begin : watch_edge
        list_result_t want;
        if (!aresetn) begin
            list_len = 0;
            awaited_results.delete();
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(apply_list_op(s_mode, 32'(s_position),
                                                        value_t'(s_value)));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result removed_value %h error %b count %0d",
                             $time, m_removed_value, m_error, m_count);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_removed_value !== want.removed) begin
                        $display("%0t: removed_value expected %h actual %h",
                                 $time, want.removed, m_removed_value);
                        fail_count++;
                    end
                    if (m_error !== want.err) begin
                        $display("%0t: error expected %b actual %b", $time, want.err, m_error);
                        fail_count++;
                    end
                    if (m_count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d",
                                 $time, want.count, m_count);
                        fail_count++;
                    end
                end
            end
        end
        pending_results = awaited_results.size();
        stored_count    = list_len;
    end

endmodule

// ===== tb/sv/positional_array_list_test.sv =====
module positional_array_list_test;
    import pal_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode          = '0;
    logic [POSITION_W-1:0]   s_position      = '0;
    logic [VALUE_PORT_W-1:0] s_value         = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [VALUE_PORT_W-1:0] m_removed_value;
    logic                    m_error;
    logic [COUNT_PORT_W-1:0] m_count;

    int   fail_count;
    int   pending_results;
    int   stored_count;
    int   idle_cycles = 0;
    logic steady      = 1'b0;

    mode_t ins_modes [3] = '{MODE_INS_POS, MODE_INS_HEAD, MODE_INS_TAIL};
    mode_t rem_modes [3] = '{MODE_REM_POS, MODE_REM_HEAD, MODE_REM_TAIL};

    positional_array_list dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_error         (m_error),
        .m_count         (m_count)
    );

    positional_array_list_check list_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_removed_value (m_removed_value),
        .m_error         (m_error),
        .m_count         (m_count),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .stored_count    (stored_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk)
        m_ready <= steady || ($urandom_range(0, 99) >= 6);

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("positional_array_list test failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [MODE_W-1:0] op, input int pos,
                             input logic [VALUE_PORT_W-1:0] val);
        while (!steady && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_mode     <= op;
        s_position <= POSITION_W'(pos);
        s_value    <= val;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
    endtask

    task automatic send_random_ops(input int n, input int ins_pct);
        logic [MODE_W-1:0] op;
        int                pos;
        logic              is_ins;
        for (int k = 0; k < n; k++) begin
            is_ins = ($urandom_range(0, 99) < ins_pct);
            if ($urandom_range(0, 99) < 5)
                op = MODE_W'(MODE_REM_TAIL) + MODE_W'($urandom_range(1, 2));
            else if (is_ins)
                op = ins_modes[$urandom_range(0, 2)];
            else
                op = rem_modes[$urandom_range(0, 2)];
            if ($urandom_range(0, 99) < 20)
                pos = $urandom_range(0, 127);
            else if (is_ins)
                pos = $urandom_range(0, (stored_count > 127) ? 127 : stored_count);
            else
                pos = (stored_count == 0) ? 0 : $urandom_range(0, stored_count - 1);
            send_item(op, pos, $urandom);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty list refusals and unused modes
        send_item(MODE_REM_HEAD, 0, 32'h0);
        send_item(MODE_REM_TAIL, 0, 32'hffff_ffff);
        send_item(MODE_REM_POS, 0, 32'h0);
        send_item(MODE_W'(MODE_REM_TAIL) + MODE_W'(1), 127, 32'hffff_ffff);
        send_item(MODE_W'(MODE_REM_TAIL) + MODE_W'(2), 0, 32'h1234_5678);
        send_item(MODE_INS_POS, 1, 32'hdead_beef);
        // inserts at every place
        send_item(MODE_INS_HEAD, 127, 32'h0);
        send_item(MODE_INS_TAIL, 0, 32'hffff_ffff);
        send_item(MODE_INS_POS, 2, 32'ha5a5_a5a5);
        send_item(MODE_INS_POS, 1, 32'h5a5a_5a5a);
        send_item(MODE_INS_POS, 0, 32'h8000_0001);
        send_item(MODE_INS_POS, 127, 32'h7fff_fffe);
        // out of range and in range removals
        send_item(MODE_REM_POS, 5, 32'h0);
        send_item(MODE_REM_POS, 127, 32'h0);
        send_item(MODE_REM_POS, 2, 32'hffff_ffff);
        send_item(MODE_REM_HEAD, 3, 32'h0);
        send_item(MODE_REM_TAIL, 0, 32'h0);
        send_item(MODE_REM_TAIL, 0, 32'h0);
        send_item(MODE_REM_HEAD, 0, 32'h0);
        send_item(MODE_REM_HEAD, 0, 32'h0);
        send_item(MODE_INS_TAIL, 0, 32'h0000_0001);
        send_item(MODE_INS_HEAD, 0, 32'h8000_0000);
        drain_results();

        send_random_ops(200, 50);
        drain_results();
        // fill up to capacity and stay there for a while
        send_random_ops(230, 85);
        drain_results();
        // empty out and sit at zero
        send_random_ops(200, 10);
        drain_results();
        steady = 1'b1;
        send_random_ops(150, 50);
        steady = 1'b0;
        drain_results();

        repeat (10) @(negedge aclk);
        if (fail_count == 0)
            $display("positional_array_list test passed");
        else
            $display("positional_array_list test failed");
        $finish;
    end

endmodule
